FILE: design/rv32d_pkg.sv
// Shared types and opcode constants for the RV32IM instruction decoder.
package rv32d_pkg;

  localparam logic [6:0] OPC_REG    = 7'h33;
  localparam logic [6:0] OPC_CUST0  = 7'h0B;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_FENCE  = 7'h0F;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_MULT = 7'h01;
  localparam logic [6:0] F7_ALT  = 7'h20;

  typedef enum logic [5:0] {
    OP_UNKNOWN = 6'd0,
    OP_ADD     = 6'd1,
    OP_SUB     = 6'd2,
    OP_SLL     = 6'd3,
    OP_SLT     = 6'd4,
    OP_SLTU    = 6'd5,
    OP_XOR     = 6'd6,
    OP_SRL     = 6'd7,
    OP_SRA     = 6'd8,
    OP_OR      = 6'd9,
    OP_AND     = 6'd10,
    OP_MUL     = 6'd11,
    OP_MULH    = 6'd12,
    OP_MULHSU  = 6'd13,
    OP_MULHU   = 6'd14,
    OP_DIV     = 6'd15,
    OP_DIVU    = 6'd16,
    OP_REM     = 6'd17,
    OP_REMU    = 6'd18,
    OP_ADDI    = 6'd19,
    OP_SLTI    = 6'd20,
    OP_SLTIU   = 6'd21,
    OP_ANDI    = 6'd22,
    OP_ORI     = 6'd23,
    OP_XORI    = 6'd24,
    OP_SLLI    = 6'd25,
    OP_SRLI    = 6'd26,
    OP_SRAI    = 6'd27,
    OP_LB      = 6'd28,
    OP_LH      = 6'd29,
    OP_LW      = 6'd30,
    OP_LBU     = 6'd31,
    OP_LHU     = 6'd32,
    OP_JALR    = 6'd33,
    OP_FENCE   = 6'd34,
    OP_ECALL   = 6'd35,
    OP_EBREAK  = 6'd36,
    OP_SB      = 6'd37,
    OP_SH      = 6'd38,
    OP_SW      = 6'd39,
    OP_LUI     = 6'd40,
    OP_AUIPC   = 6'd41,
    OP_JAL     = 6'd42,
    OP_BEQ     = 6'd43,
    OP_BNE     = 6'd44,
    OP_BLT     = 6'd45,
    OP_BGE     = 6'd46,
    OP_BLTU    = 6'd47,
    OP_BGEU    = 6'd48
  } op_e;

  typedef struct packed {
    logic [5:0]         operation;
    logic [4:0]         dest_reg;
    logic [4:0]         src1_reg;
    logic [4:0]         src2_reg;
    logic signed [31:0] immediate;
  } dec_t;

endpackage

FILE: design/rv32d_instr_if.sv
// Valid/ready channel carrying one raw instruction word per beat.
interface rv32d_instr_if;
  logic        valid;
  logic        ready;
  logic [31:0] instruction_word;

  modport source (output valid, output instruction_word, input ready);
  modport sink   (input valid, input instruction_word, output ready);
endinterface

FILE: design/rv32d_dec_if.sv
// Valid/ready channel carrying one decoded instruction per beat.
interface rv32d_dec_if;
  logic               valid;
  logic               ready;
  logic [5:0]         operation;
  logic [4:0]         dest_reg;
  logic [4:0]         src1_reg;
  logic [4:0]         src2_reg;
  logic signed [31:0] immediate;

  modport source (output valid, output operation, output dest_reg, output src1_reg,
                  output src2_reg, output immediate, input ready);
  modport sink   (input valid, input operation, input dest_reg, input src1_reg,
                  input src2_reg, input immediate, output ready);
endinterface

FILE: design/rv32im_instruction_decoder.sv
// RV32IM instruction decoder: input register, decode logic, result register.
// An accepted instruction beat passes the input register, then the result register.
// Throughput: one instruction per cycle unless stalled; both registers advance
// together and a stalled output lets the input register fill (two beats buffered).
// Reset (rst_ni low, asynchronous) empties both stages; data registers are not reset.
module rv32im_instruction_decoder
  import rv32d_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  rv32d_instr_if.sink instr_i,
  rv32d_dec_if.source dec_o
);

  logic        in_vld_q;
  logic        in_vld_d;
  logic [31:0] word_q;
  logic        out_vld_q;
  logic        out_vld_d;
  dec_t        dec_q;
  dec_t        dec_d;
  logic        out_rdy;
  logic        in_rdy;

  assign out_rdy = !out_vld_q || dec_o.ready;
  assign in_rdy  = !in_vld_q || out_rdy;
  assign instr_i.ready = in_rdy;

  assign in_vld_d  = in_rdy ? instr_i.valid : in_vld_q;
  assign out_vld_d = out_rdy ? in_vld_q : out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && instr_i.valid) begin
      word_q <= instr_i.instruction_word;
    end
    if (out_rdy && in_vld_q) begin
      dec_q <= dec_d;
    end
  end

  // decode
  logic [6:0]  major;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [4:0]  rs1;
  logic [4:0]  rs2;
  logic [6:0]  f7;
  logic [11:0] i12;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] imm_u;
  logic [31:0] shamt;

  assign major = word_q[6:0];
  assign rd    = word_q[11:7];
  assign f3    = word_q[14:12];
  assign rs1   = word_q[19:15];
  assign rs2   = word_q[24:20];
  assign f7    = word_q[31:25];
  assign i12   = word_q[31:20];
  assign imm_i = {{20{word_q[31]}}, i12};
  assign imm_s = {{20{word_q[31]}}, f7, rd};
  assign imm_b = {{20{word_q[31]}}, word_q[7], word_q[30:25], word_q[11:8], 1'b0};
  assign imm_j = {{12{word_q[31]}}, word_q[19:12], word_q[20], word_q[30:21], 1'b0};
  assign imm_u = {word_q[31:12], 12'h000};
  assign shamt = {27'd0, rs2};

  always_comb begin
    dec_d = '0;
    unique case (major) inside
      OPC_REG, OPC_CUST0: begin
        dec_d.dest_reg = rd;
        dec_d.src1_reg = rs1;
        dec_d.src2_reg = rs2;
        if (f7 == F7_MULT) begin
          dec_d.operation = OP_MUL + {3'd0, f3};
        end else begin
          case (f3)
            3'd0: dec_d.operation = (f7 == F7_BASE) ? OP_ADD :
                                    (f7 == F7_ALT)  ? OP_SUB : OP_UNKNOWN;
            3'd1: dec_d.operation = OP_SLL;
            3'd2: dec_d.operation = OP_SLT;
            3'd3: dec_d.operation = OP_SLTU;
            3'd4: dec_d.operation = OP_XOR;
            3'd5: dec_d.operation = (f7 == F7_BASE) ? OP_SRL :
                                    (f7 == F7_ALT)  ? OP_SRA : OP_UNKNOWN;
            3'd6: dec_d.operation = OP_OR;
            default: dec_d.operation = OP_AND;
          endcase
        end
      end
      OPC_OPIMM: begin
        dec_d.dest_reg  = rd;
        dec_d.src1_reg  = rs1;
        dec_d.immediate = imm_i;
        case (f3)
          3'd0: dec_d.operation = OP_ADDI;
          3'd1: begin
            dec_d.operation = OP_SLLI;
            dec_d.immediate = shamt;
          end
          3'd2: dec_d.operation = OP_SLTI;
          3'd3: dec_d.operation = OP_SLTIU;
          3'd4: dec_d.operation = OP_XORI;
          3'd5: begin
            if (f7 == F7_BASE) begin
              dec_d.operation = OP_SRLI;
              dec_d.immediate = shamt;
            end else if (f7 == F7_ALT) begin
              dec_d.operation = OP_SRAI;
              dec_d.immediate = shamt;
            end
          end
          3'd6: dec_d.operation = OP_ORI;
          default: dec_d.operation = OP_ANDI;
        endcase
      end
      OPC_LOAD: begin
        dec_d.dest_reg  = rd;
        dec_d.src1_reg  = rs1;
        dec_d.immediate = imm_i;
        case (f3)
          3'd0: dec_d.operation = OP_LB;
          3'd1: dec_d.operation = OP_LH;
          3'd2: dec_d.operation = OP_LW;
          3'd4: dec_d.operation = OP_LBU;
          3'd5: dec_d.operation = OP_LHU;
          default: dec_d.operation = OP_UNKNOWN;
        endcase
      end
      OPC_JALR, OPC_FENCE: begin
        dec_d.dest_reg  = rd;
        dec_d.src1_reg  = rs1;
        dec_d.immediate = imm_i;
        dec_d.operation = (major == OPC_JALR) ? OP_JALR : OP_FENCE;
      end
      OPC_SYSTEM: begin
        dec_d.dest_reg  = rd;
        dec_d.src1_reg  = rs1;
        dec_d.immediate = imm_i;
        if (f3 == 3'd0 && i12 == 12'd0) begin
          dec_d.operation = OP_ECALL;
        end else if (f3 == 3'd0 && i12 == 12'd1) begin
          dec_d.operation = OP_EBREAK;
        end
      end
      OPC_STORE: begin
        dec_d.src1_reg  = rs1;
        dec_d.src2_reg  = rs2;
        dec_d.immediate = imm_s;
        case (f3)
          3'd0: dec_d.operation = OP_SB;
          3'd1: dec_d.operation = OP_SH;
          3'd2: dec_d.operation = OP_SW;
          default: dec_d.operation = OP_UNKNOWN;
        endcase
      end
      OPC_LUI, OPC_AUIPC: begin
        dec_d.dest_reg  = rd;
        dec_d.immediate = imm_u;
        dec_d.operation = (major == OPC_LUI) ? OP_LUI : OP_AUIPC;
      end
      OPC_JAL: begin
        dec_d.dest_reg  = rd;
        dec_d.immediate = imm_j;
        dec_d.operation = OP_JAL;
      end
      OPC_BRANCH: begin
        dec_d.src1_reg  = rs1;
        dec_d.src2_reg  = rs2;
        dec_d.immediate = imm_b;
        case (f3)
          3'd0: dec_d.operation = OP_BEQ;
          3'd1: dec_d.operation = OP_BNE;
          3'd4: dec_d.operation = OP_BLT;
          3'd5: dec_d.operation = OP_BGE;
          3'd6: dec_d.operation = OP_BLTU;
          3'd7: dec_d.operation = OP_BGEU;
          default: dec_d.operation = OP_UNKNOWN;
        endcase
      end
      default: dec_d = '0;
    endcase
  end

  assign dec_o.valid     = out_vld_q;
  assign dec_o.operation = dec_q.operation;
  assign dec_o.dest_reg  = dec_q.dest_reg;
  assign dec_o.src1_reg  = dec_q.src1_reg;
  assign dec_o.src2_reg  = dec_q.src2_reg;
  assign dec_o.immediate = dec_q.immediate;

  // input stage holds its beat while the result register is blocked
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !out_rdy |=> in_vld_q && $stable(word_q))
    else $error("input stage lost or changed a stalled beat");

  // backpressure only when both stages are occupied
  a_rdy_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !instr_i.ready |-> in_vld_q && out_vld_q && !dec_o.ready)
    else $error("input stalled with a free stage");

  // stores and branches never carry a destination register
  a_no_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dec_o.valid && (dec_o.operation == OP_SB || dec_o.operation == OP_SH ||
                    dec_o.operation == OP_SW || dec_o.operation == OP_BEQ ||
                    dec_o.operation == OP_BNE || dec_o.operation == OP_BLT ||
                    dec_o.operation == OP_BGE || dec_o.operation == OP_BLTU ||
                    dec_o.operation == OP_BGEU) |-> dec_o.dest_reg == 5'd0)
    else $error("store or branch with nonzero rd");

endmodule
